// ===== sv/grc_pkg.sv =====
// ----------------------------------------------------------------------------
// grid ray caster package
// shared types and constants for the dda ray caster
// ----------------------------------------------------------------------------
`default_nettype none
package grc_pkg;

  localparam int MapBits  = 6;
  localparam int MapSize  = 1 << MapBits;
  localparam int ScrBits  = 10;
  localparam int FracBits = 16;
  localparam int MaxSteps = 2 * MapSize + 4;

  localparam logic [1:0] KindEmpty = 2'd0;
  localparam logic [1:0] KindWall  = 2'd1;
  localparam logic [1:0] KindDoor  = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdCast  = 1'b1;

  localparam logic [2:0] RegPlayerX = 3'd0;
  localparam logic [2:0] RegPlayerY = 3'd1;
  localparam logic [2:0] RegDirX    = 3'd2;
  localparam logic [2:0] RegDirY    = 3'd3;
  localparam logic [2:0] RegPlaneX  = 3'd4;
  localparam logic [2:0] RegPlaneY  = 3'd5;
  localparam logic [2:0] RegDoor    = 3'd6;

  typedef struct packed {
    logic        command;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic [1:0]  cell_kind;
    logic [9:0]  column;
  } grc_in_t;

  typedef struct packed {
    logic [23:0] perp_distance;
    logic [1:0]  face;
    logic        hit_door;
    logic [15:0] tex_frac;
  } grc_out_t;

  typedef enum logic [4:0] {
    StClear, StIdle, StRayX, StRayY, StDivX, StDivY, StSideX, StSideXb,
    StSideY, StSideYb, StRead, StWait, StCheck, StDoorA, StDoorB, StAdv,
    StTexA, StTexB, StOut
  } grc_state_e;

endpackage
`default_nettype wire

// ===== sv/grid_raycast_dda.sv =====
// ----------------------------------------------------------------------------
// grid ray caster top level
// loads a 64x64 cell map and casts one ray per column by dda
// ----------------------------------------------------------------------------
// channel  direction  handshake        beat
// in       input      in_valid/stall   command, cell, column
// out      output     out_valid/stall  distance, face, door flag, texture
// cfg      input      valid/ready      register index and data
//
// a write is stored as it is accepted; a cast runs two 41-step restoring
// divisions on one shared divider, then one map read per cell stepped and a
// distance check per closed door cell met. after reset a clearing pass
// empties the map before any beat is taken. a result waits in the output
// register until out_stall is low; a cast that finishes while it still waits
// is held in its last state.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_raycast_dda (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output      logic             in_stall_o,
  input  wire grc_pkg::grc_in_t  in_data_i,
  output      logic             out_valid_o,
  input  wire logic             out_stall_i,
  output      grc_pkg::grc_out_t out_data_o,
  input  wire logic             cfg_valid_i,
  output      logic             cfg_ready_o,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [21:0]      cfg_data_i
);
  import grc_pkg::*;

  grc_state_e state_q, state_d;

  logic [21:0] px_q, py_q;
  logic signed [18:0] dirx_q, diry_q, plx_q, ply_q;
  logic door_open_q;

  logic [1:0] map_mem [MapSize*MapSize];
  logic [1:0] rd_q;
  logic [11:0] clr_q;

  logic signed [17:0] cam_q;
  logic signed [20:0] rx_q, ry_q;
  logic [40:0] dlx_q, dly_q;
  logic [47:0] sdx_q, sdy_q;
  logic signed [8:0] cx_q, cy_q;
  logic [7:0] n_q;
  logic last_q, stepped_q, door_hit_q;
  logic [23:0] dist_q;
  logic [15:0] tex_q;
  logic [1:0] face_q;
  logic out_valid_q;
  grc_out_t out_q;

  // shared divider: 2^32 / a, restoring, one quotient bit per cycle
  logic [5:0]  dcnt_q;
  logic [33:0] drem_q;
  logic [40:0] dquo_q;
  logic [20:0] dden_q;

  // shared multiplier operands and registered product
  logic signed [25:0] ma, mb;
  logic signed [51:0] prod;
  logic signed [51:0] prod_q;

  function automatic logic [20:0] abs21(input logic signed [20:0] v);
    return v[20] ? 21'(-v) : 21'(v);
  endfunction

  logic cfg_we, in_acc, map_we, out_load;
  logic [11:0] map_wa;
  logic [1:0]  map_wd;
  logic [11:0] rd_addr;
  logic signed [22:0] ddx, ddy;
  logic offmap;
  logic [16:0] fx_sel, fy_sel;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i;
  assign in_stall_o = (state_q != StIdle);
  assign in_acc = in_valid_i && (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign out_load = (state_q == StOut) && (!out_valid_q || !out_stall_i);
  assign prod = ma * mb;
  assign rd_addr = {cy_q[5:0], cx_q[5:0]};
  assign offmap = cx_q[8] || cy_q[8] || (cx_q[7:6] != 2'b00) || (cy_q[7:6] != 2'b00);
  assign ddx = 23'(signed'({1'b0, px_q})) - 23'(signed'({1'b0, cx_q[5:0], 16'h0}));
  assign ddy = 23'(signed'({1'b0, py_q})) - 23'(signed'({1'b0, cy_q[5:0], 16'h0}));
  assign fx_sel = (rx_q[20] || rx_q == 0) ? {1'b0, px_q[15:0]}
                                           : 17'h10000 - {1'b0, px_q[15:0]};
  assign fy_sel = ry_q[20] ? {1'b0, py_q[15:0]} : 17'h10000 - {1'b0, py_q[15:0]};

  always_comb begin
    map_we = 1'b0;
    map_wa = clr_q;
    map_wd = KindEmpty;
    if (state_q == StClear) begin
      map_we = 1'b1;
    end else if (in_acc && in_data_i.command == CmdWrite) begin
      map_we = 1'b1;
      map_wa = {in_data_i.cell_y, in_data_i.cell_x};
      map_wd = (in_data_i.cell_kind == KindSpare) ? KindEmpty : in_data_i.cell_kind;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    rd_q <= map_mem[rd_addr];
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state_q)
      StRayX:   begin ma = 26'(cam_q); mb = 26'(plx_q); end
      StRayY:   begin ma = 26'(cam_q); mb = 26'(ply_q); end
      StSideX:  begin ma = 26'(fx_sel); mb = 26'(dlx_q[40:16]); end
      StSideXb: begin ma = 26'(fx_sel); mb = 26'(dlx_q[15:0]); end
      StSideY:  begin ma = 26'(fy_sel); mb = 26'(dly_q[40:16]); end
      StSideYb: begin ma = 26'(fy_sel); mb = 26'(dly_q[15:0]); end
      StDoorA:  begin ma = 26'(ddx); mb = 26'(ddx); end
      StDoorB:  begin ma = 26'(ddy); mb = 26'(ddy); end
      StTexA:   begin ma = last_q ? 26'(rx_q) : 26'(ry_q); mb = 26'({1'b0, dist_q}); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear:  if (clr_q == 12'hfff) state_d = StIdle;
      StIdle:   if (in_acc && in_data_i.command == CmdCast) state_d = StRayX;
      StRayX:   state_d = StRayY;
      StRayY:   state_d = StDivX;
      StDivX:   if (dcnt_q == 6'd0) state_d = StDivY;
      StDivY:   if (dcnt_q == 6'd0) state_d = StSideX;
      StSideX:  state_d = StSideXb;
      StSideXb: state_d = StSideY;
      StSideY:  state_d = StSideYb;
      StSideYb: state_d = StRead;
      StRead:   state_d = StWait;
      StWait:   state_d = StCheck;
      StCheck:  begin
        if (n_q == 8'(MaxSteps)) state_d = StTexA;
        else if (offmap || rd_q == KindWall) state_d = StTexA;
        else if (rd_q == KindDoor && door_open_q) state_d = StTexA;
        else if (rd_q == KindDoor) state_d = StDoorA;
        else state_d = StAdv;
      end
      StDoorA:  state_d = StDoorB;
      StDoorB:  begin
        if (ddx > 23'sd131072 || ddx < -23'sd131072 || ddy > 23'sd131072
            || ddy < -23'sd131072 || 64'(prod_q) + 64'(prod) > 64'h4_0000_0000)
          state_d = StTexA;
        else state_d = StAdv;
      end
      StAdv:    state_d = StRead;
      StTexA:   state_d = StTexB;
      StTexB:   state_d = StOut;
      StOut:    if (out_load) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      px_q <= '0;
      py_q <= '0;
      dirx_q <= 19'sd65536;
      diry_q <= '0;
      plx_q <= '0;
      ply_q <= 19'sd43254;
      door_open_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StClear) clr_q <= clr_q + 12'd1;
      if (cfg_we) begin
        unique case (cfg_index_i)
          RegPlayerX: px_q <= cfg_data_i;
          RegPlayerY: py_q <= cfg_data_i;
          RegDirX:    dirx_q <= cfg_data_i[18:0];
          RegDirY:    diry_q <= cfg_data_i[18:0];
          RegPlaneX:  plx_q <= cfg_data_i[18:0];
          RegPlaneY:  ply_q <= cfg_data_i[18:0];
          RegDoor:    door_open_q <= cfg_data_i[0];
          default:    ;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    if (out_load) begin
      out_q <= '{perp_distance: dist_q, face: face_q, hit_door: door_hit_q,
                 tex_frac: tex_q};
    end
    unique case (state_q)
      StIdle: begin
        cam_q <= 18'(signed'({1'b0, in_data_i.column, 7'd0})) - 18'sd65536;
      end
      StRayX: rx_q <= 21'(dirx_q) + 21'(prod >>> FracBits);
      StRayY: begin
        ry_q <= 21'(diry_q) + 21'(prod >>> FracBits);
        dden_q <= abs21(rx_q);
        drem_q <= '0;
        dquo_q <= '0;
        dcnt_q <= 6'd40;
      end
      StDivX, StDivY: begin
        logic [33:0] t;
        logic [33:0] r;
        logic [41:0] q;
        t = {drem_q[32:0], (dcnt_q == 6'd32)};
        if (t >= 34'(dden_q)) begin
          r = t - 34'(dden_q);
          q = {dquo_q, 1'b1};
        end else begin
          r = t;
          q = {dquo_q, 1'b0};
        end
        if (dcnt_q == 6'd0 && state_q == StDivX) begin
          dlx_q <= (dden_q == 0 || q[40]) ? 41'h100_0000_0000 : q[40:0];
          dden_q <= abs21(ry_q);
          drem_q <= '0;
          dquo_q <= '0;
          dcnt_q <= 6'd40;
        end else begin
          drem_q <= r;
          dquo_q <= q[40:0];
          dcnt_q <= dcnt_q - 6'd1;
          if (dcnt_q == 6'd0) begin
            dly_q <= (dden_q == 0 || q[40]) ? 41'h100_0000_0000 : q[40:0];
          end
        end
      end
      StSideXb: sdx_q <= 48'(prod_q) + 48'(prod >>> FracBits);
      StSideYb: begin
        sdy_q <= 48'(prod_q) + 48'(prod >>> FracBits);
        cx_q <= {3'b000, px_q[21:16]};
        cy_q <= {3'b000, py_q[21:16]};
        n_q <= '0;
        stepped_q <= 1'b0;
        door_hit_q <= 1'b0;
        last_q <= 1'b0;
      end
      StCheck: begin
        if (n_q != 8'(MaxSteps) && !offmap && rd_q == KindDoor && door_open_q)
          door_hit_q <= 1'b1;
      end
      StDoorB: begin
        if (ddx > 23'sd131072 || ddx < -23'sd131072 || ddy > 23'sd131072
            || ddy < -23'sd131072 || 64'(prod_q) + 64'(prod) > 64'h4_0000_0000)
          door_hit_q <= 1'b1;
      end
      StAdv: begin
        n_q <= n_q + 8'd1;
        stepped_q <= 1'b1;
        if (sdx_q < sdy_q) begin
          sdx_q <= sdx_q + 48'(dlx_q);
          cx_q <= (rx_q > 0) ? cx_q + 9'sd1 : cx_q - 9'sd1;
          last_q <= 1'b0;
        end else begin
          sdy_q <= sdy_q + 48'(dly_q);
          cy_q <= ry_q[20] ? cy_q - 9'sd1 : cy_q + 9'sd1;
          last_q <= 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == StCheck || state_q == StDoorB) begin
      logic [47:0] dd;
      dd = last_q ? sdy_q - 48'(dly_q) : sdx_q - 48'(dlx_q);
      dist_q <= !stepped_q ? 24'd0 : (dd > 48'hFFFFFF ? 24'hFFFFFF : dd[23:0]);
      face_q <= !stepped_q ? 2'd0 : last_q ? (ry_q > 0 ? 2'd2 : 2'd3)
                                           : (rx_q > 0 ? 2'd0 : 2'd1);
    end
    if (state_q == StTexB) begin
      logic [43:0] w;
      w = 44'(prod_q >>> FracBits) + (last_q ? 44'(px_q) : 44'(py_q));
      tex_q <= stepped_q ? w[15:0] : 16'd0;
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid ray caster testbench
// loads cell maps, casts rays under several camera settings and checks every
// result beat against a fixed point dda predictor kept inside the bench
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import grc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  grc_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  grc_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;

  always #5 clk = ~clk;

  grid_raycast_dda i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  localparam longint One   = 64'sd1 << FracBits;
  localparam longint StepCap = 64'sd1 << (FracBits + 24);

  logic [1:0]  cell_map [MapSize*MapSize];
  longint      pos_x, pos_y, dir_x, dir_y, plane_x, plane_y;
  logic        doors_open;

  grc_in_t     beat_q [$];
  grc_out_t    hit_q [$];
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          errors = 0;
  int          quiet_cycles = 0;
  bit          casting = 1'b0;

  function automatic longint sx19(logic [21:0] v);
    return longint'($signed(v[18:0]));
  endfunction

  function automatic longint floor_shr(longint v);
    return v >>> FracBits;
  endfunction

  function automatic longint step_length(longint r);
    longint a, d;
    a = r < 0 ? -r : r;
    if (a == 0) return StepCap;
    d = (64'sd1 << (2 * FracBits)) / a;
    return d > StepCap ? StepCap : d;
  endfunction

  function automatic longint frac_scale(longint f, longint d);
    return f * (d >>> FracBits) + ((f * (d & (One - 1))) >>> FracBits);
  endfunction

  function automatic logic [1:0] map_kind(longint x, longint y);
    if (x < 0 || y < 0 || x >= MapSize || y >= MapSize) return KindWall;
    return cell_map[y * MapSize + x];
  endfunction

  function automatic bit door_is_far(longint cx, longint cy);
    longint dx, dy;
    dx = pos_x - (cx << FracBits);
    dy = pos_y - (cy << FracBits);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (dx > 2 * One || dy > 2 * One) return 1'b1;
    return (dx * dx + dy * dy) > (64'sd4 << (2 * FracBits));
  endfunction

  function automatic grc_out_t cast_ray(logic [9:0] col);
    grc_out_t r;
    longint cam, rx, ry, cx, cy, stx, sty, dlx, dly, side_x, side_y, d, w;
    logic [1:0] k;
    int last;
    r = '0;
    last = -1;
    cam = ((longint'(col) * 2) << FracBits) / (1 << ScrBits) - One;
    rx = dir_x + floor_shr(cam * plane_x);
    ry = dir_y + floor_shr(cam * plane_y);
    cx = pos_x >>> FracBits;
    cy = pos_y >>> FracBits;
    dlx = step_length(rx);
    dly = step_length(ry);
    stx = rx > 0 ? 1 : -1;
    sty = ry < 0 ? -1 : 1;
    side_x = frac_scale(rx > 0 ? One - (pos_x & (One - 1)) : pos_x & (One - 1), dlx);
    side_y = frac_scale(ry < 0 ? pos_y & (One - 1) : One - (pos_y & (One - 1)), dly);
    for (int n = 0; n < MaxSteps; n++) begin
      k = map_kind(cx, cy);
      if (k == KindWall) break;
      if (k == KindDoor && (doors_open || door_is_far(cx, cy))) begin
        r.hit_door = 1'b1;
        break;
      end
      if (side_x < side_y) begin
        side_x += dlx;
        cx += stx;
        last = 0;
      end else begin
        side_y += dly;
        cy += sty;
        last = 1;
      end
    end
    if (last == 0) begin
      d = side_x - dlx;
      if (d > 64'hFFFFFF) d = 64'hFFFFFF;
      r.face = rx > 0 ? 2'd0 : 2'd1;
      w = floor_shr(ry * d) + pos_y;
      r.tex_frac = w[15:0];
      r.perp_distance = d[23:0];
    end else if (last == 1) begin
      d = side_y - dly;
      if (d > 64'hFFFFFF) d = 64'hFFFFFF;
      r.face = ry > 0 ? 2'd2 : 2'd3;
      w = floor_shr(rx * d) + pos_x;
      r.tex_frac = w[15:0];
      r.perp_distance = d[23:0];
    end
    return r;
  endfunction

  // driver: pending beats go out one by one, prediction at acceptance
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        if (in_data.command == CmdWrite) begin
          cell_map[in_data.cell_y * MapSize + in_data.cell_x] <=
            in_data.cell_kind == KindSpare ? KindEmpty : in_data.cell_kind;
        end else begin
          hit_q.push_back(cast_ray(in_data.column));
        end
        beat_q.pop_front();
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= beat_q[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    grc_out_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid || !casting)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (out_valid && !out_stall) begin
        if (hit_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_r = hit_q.pop_front();
          if (out_data.perp_distance !== exp_r.perp_distance) begin
            $error("perp_distance exp %0d got %0d", exp_r.perp_distance,
                   out_data.perp_distance);
            errors++;
          end
          if (out_data.face !== exp_r.face) begin
            $error("face exp %0d got %0d", exp_r.face, out_data.face);
            errors++;
          end
          if (out_data.hit_door !== exp_r.hit_door) begin
            $error("hit_door exp %0d got %0d", exp_r.hit_door, out_data.hit_door);
            errors++;
          end
          if (out_data.tex_frac !== exp_r.tex_frac) begin
            $error("tex_frac exp %0d got %0d", exp_r.tex_frac, out_data.tex_frac);
            errors++;
          end
        end
      end
      if (quiet_cycles > 20000) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [21:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      RegPlayerX: pos_x = val;
      RegPlayerY: pos_y = val;
      RegDirX:    dir_x = sx19(val);
      RegDirY:    dir_y = sx19(val);
      RegPlaneX:  plane_x = sx19(val);
      RegPlaneY:  plane_y = sx19(val);
      default:    doors_open = val[0];
    endcase
  endtask

  task automatic drain;
    casting = 1'b1;
    while (beat_q.size() != 0 || hit_q.size() != 0) @(posedge clk);
    casting = 1'b0;
    repeat (700) @(posedge clk);
  endtask

  function automatic grc_in_t wr(int x, int y, int k);
    grc_in_t b;
    b = '0;
    b.command = CmdWrite;
    b.cell_x = 6'(x);
    b.cell_y = 6'(y);
    b.cell_kind = 2'(k);
    b.column = 10'($urandom());
    return b;
  endfunction

  function automatic grc_in_t ray(int c);
    grc_in_t b;
    b = grc_in_t'($urandom());
    b.command = CmdCast;
    b.column = 10'(c);
    return b;
  endfunction

  task automatic random_view;
    reg_write(RegPlayerX, 22'($urandom_range(10, 53) << 16 | $urandom_range(65535)));
    reg_write(RegPlayerY, 22'($urandom_range(10, 53) << 16 | $urandom_range(65535)));
    reg_write(RegDirX, 22'($urandom()));
    reg_write(RegDirY, 22'($urandom()));
    reg_write(RegPlaneX, 22'($urandom()));
    reg_write(RegPlaneY, 22'($urandom()));
    reg_write(RegDoor, 22'($urandom()));
  endtask

  task automatic random_phase(int n);
    int x, y;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 40) begin
        x = $urandom_range(99) < 70 ? int'((pos_x >>> 16) + $urandom_range(6) - 3)
                                    : int'($urandom_range(63));
        y = $urandom_range(99) < 70 ? int'((pos_y >>> 16) + $urandom_range(6) - 3)
                                    : int'($urandom_range(63));
        beat_q.push_back(wr(x & 63, y & 63, int'($urandom_range(3))));
      end else begin
        beat_q.push_back(ray(int'($urandom_range(1023))));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MapSize * MapSize; i++) cell_map[i] = KindEmpty;
    pos_x = 0; pos_y = 0; dir_x = 65536; dir_y = 0; plane_x = 0; plane_y = 43254;
    doors_open = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset view from the map corner, start in the opposite corner, doors near and far
    beat_q.push_back(ray(0));
    beat_q.push_back(ray(1023));
    drain();
    reg_write(RegPlayerX, (22'd5 << 16) | 22'h8000);
    reg_write(RegPlayerY, (22'd5 << 16) | 22'h4000);
    beat_q.push_back(wr(5, 5, 2));
    beat_q.push_back(ray(512));
    beat_q.push_back(wr(7, 5, 2));
    beat_q.push_back(wr(8, 5, 1));
    beat_q.push_back(ray(512));
    beat_q.push_back(wr(5, 5, 3));
    beat_q.push_back(wr(63, 63, 1));
    beat_q.push_back(wr(0, 0, 2));
    beat_q.push_back(ray(300));
    beat_q.push_back(ray(700));
    drain();
    reg_write(RegDoor, 22'd1);
    reg_write(RegDirX, 22'h40000);
    reg_write(RegDirY, 22'h3FFFF);
    reg_write(RegPlaneX, 22'h3FFFF);
    reg_write(RegPlaneY, 22'h40000);
    beat_q.push_back(ray(0));
    beat_q.push_back(ray(1023));
    beat_q.push_back(ray(512));
    drain();
    reg_write(RegDirY, 22'd0);
    reg_write(RegPlaneX, 22'd0);
    reg_write(RegPlayerX, 22'h3FFFFF);
    reg_write(RegPlayerY, 22'h3FFFFF);
    beat_q.push_back(ray(512));
    beat_q.push_back(ray(777));
    drain();

    for (int p = 0; p < 18; p++) begin
      if (p < 6) begin
        send_idle_pct = 21; recv_idle_pct = 49;
      end else if (p < 12) begin
        send_idle_pct = 49; recv_idle_pct = 21;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      random_view();
      random_phase(100);
      drain();
    end

    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire
